// ----- rtl/vfbc_pkg.sv -----
// Package for the view frustum box cull block.
// Holds the plane table, the fixed-point constants and the pipeline control type.
// No dependencies.
`default_nettype none

package vfbc_pkg;

  // The six clip planes.
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int MAT_DEPTH  = 16;
  localparam int FRAC_BITS  = 16;

  // Command codes of an input request.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Axis and sign (1 = plus) of each plane: w-x, w+x, w+y, w-y, w-z, w+z.
  localparam logic [1:0] PLANE_AXIS [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic       PLANE_PLUS [NUM_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  // Control that travels alongside the data in each pipeline stage.
  typedef struct packed {
    logic valid;
    logic is_test;
    logic has_body;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/vfbc_if.sv -----
// Channel interfaces of the view frustum box cull block.
// The request channel and the result channel, each with valid/ready.
// No dependencies.
`default_nettype none

interface vfbc_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [1:0]          column;
  logic                has_body;
  logic signed [W-1:0] val0;
  logic signed [W-1:0] val1;
  logic signed [W-1:0] val2;
  logic signed [W-1:0] val3;
  logic signed [W-1:0] val4;
  logic signed [W-1:0] val5;

  modport source (output valid, cmd, column, has_body, val0, val1, val2, val3, val4, val5,
                  input ready);
  modport sink   (input valid, cmd, column, has_body, val0, val1, val2, val3, val4, val5,
                  output ready);
endinterface

interface vfbc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic is_test;

  modport source (output valid, inside_res, is_test, input ready);
  modport sink   (input valid, inside_res, is_test, output ready);
endinterface

`default_nettype wire

// ----- rtl/vfbc_plane_eval.sv -----
// One clip plane test: products, partial sums and the sign of the farthest corner.
// Three register stages, all advanced by a common enable.
// Depends on vfbc_pkg.
`default_nettype none

module vfbc_plane_eval
  import vfbc_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [W:0]     n   [NUM_AXES],
  input  wire logic        [W:0]     nabs[NUM_AXES],
  input  wire logic signed [W-1:0]   c   [NUM_AXES],
  input  wire logic        [W:0]     s   [NUM_AXES],
  input  wire logic signed [W:0]     d,
  output logic                       neg
);

  localparam int PCW = 2 * W + 1;
  localparam int PSW = 2 * W + 2;
  localparam int ACC = 2 * W + 6;

  logic signed [PCW-1:0] pc_r[NUM_AXES];
  logic        [PSW-1:0] ps_r[NUM_AXES];
  logic signed [W:0]     d_r;
  logic signed [ACC-1:0] t_r [NUM_AXES];
  logic signed [ACC-1:0] dd_r;
  logic signed [ACC-1:0] sum_nxt;
  logic                  neg_r;

  // Stage A: signed centre products and unsigned extent products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pc_r[i] <= PCW'(n[i] * c[i]);
        ps_r[i] <= nabs[i] * s[i];
      end
      d_r <= d;
    end
  end

  // Stage B: add the two products of each axis and align the constant to Q32.32.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        t_r[i] <= ACC'(pc_r[i]) + $signed(ACC'(ps_r[i]));
      end
      dd_r <= ACC'(d_r) <<< FRAC_BITS;
    end
  end

  // Stage C: the farthest corner value; only its sign is kept.
  assign sum_nxt = t_r[0] + t_r[1] + t_r[2] + dd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= sum_nxt[ACC-1];
    end
  end

  assign neg = neg_r;

endmodule

`default_nettype wire

// ----- rtl/view_frustum_box_cull.sv -----
// Top level of the view frustum box cull block.
// Depends on vfbc_pkg, vfbc_if and vfbc_plane_eval.
//
// Streams load and test requests at one per cycle unless stalled. A load
// request writes one column of the view-projection matrix and is acknowledged;
// a test request checks a box against the six clip planes and reports whether
// it touches or lies inside the frustum. Each request passes through one stage
// that derives the planes and box extents, three stages per plane that multiply
// and sum, and the result register that forms the verdict. The matrix is
// written at accept time, so a test that directly follows a load already sees
// the new column. The whole pipeline halts while a result waits to be taken.
`default_nettype none

module view_frustum_box_cull
  import vfbc_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vfbc_in_if.sink   in_if,
  vfbc_out_if.source out_if
);

  localparam int W = VALUE_WIDTH;

  logic                en;
  logic                in_acc;
  logic signed [W-1:0] mat_r[MAT_DEPTH];

  logic signed [W:0]   n_r   [NUM_PLANES][NUM_AXES];
  logic        [W:0]   nabs_r[NUM_PLANES][NUM_AXES];
  logic signed [W:0]   d_r   [NUM_PLANES];
  logic signed [W-1:0] c_r   [NUM_AXES];
  logic        [W:0]   s_r   [NUM_AXES];

  ctl_t                ctl_r[4];
  logic [NUM_PLANES-1:0] neg;

  logic out_valid_r;
  logic inside_r;
  logic is_test_r;

  // The pipeline moves unless a result is waiting.
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;
  assign in_acc      = in_if.valid && en;

  // Matrix storage, written one column per load request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_DEPTH; i++) mat_r[i] <= '0;
    end else if (in_acc && in_if.cmd == CMD_LOAD) begin
      mat_r[{in_if.column, 2'd0}] <= in_if.val0;
      mat_r[{in_if.column, 2'd1}] <= in_if.val1;
      mat_r[{in_if.column, 2'd2}] <= in_if.val2;
      mat_r[{in_if.column, 2'd3}] <= in_if.val3;
    end
  end

  // Stage one: plane normals and constants, box centre and half extent.
  always_ff @(posedge clk) begin
    logic signed [W:0] nv;
    logic signed [W:0] df;
    logic signed [W-1:0] cv[NUM_AXES];
    logic signed [W-1:0] mv[NUM_AXES];
    if (en) begin
      cv = '{in_if.val0, in_if.val1, in_if.val2};
      mv = '{in_if.val3, in_if.val4, in_if.val5};
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          nv = PLANE_PLUS[p]
             ? (W+1)'(mat_r[i*4+3]) + (W+1)'(mat_r[i*4+PLANE_AXIS[p]])
             : (W+1)'(mat_r[i*4+3]) - (W+1)'(mat_r[i*4+PLANE_AXIS[p]]);
          n_r[p][i]    <= nv;
          nabs_r[p][i] <= nv[W] ? -nv : nv;
        end
        d_r[p] <= PLANE_PLUS[p]
                ? (W+1)'(mat_r[15]) + (W+1)'(mat_r[12+PLANE_AXIS[p]])
                : (W+1)'(mat_r[15]) - (W+1)'(mat_r[12+PLANE_AXIS[p]]);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        df      = (W+1)'(mv[i]) - (W+1)'(cv[i]);
        c_r[i] <= cv[i];
        s_r[i] <= df[W] ? -df : df;
      end
    end
  end

  // Control of each stage travels with its data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) ctl_r[k] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: in_if.valid, is_test: in_if.cmd == CMD_TEST,
                    has_body: in_if.has_body};
      for (int k = 1; k < 4; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // One evaluator per clip plane.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    vfbc_plane_eval #(.W(W)) u_plane (
      .clk  (clk),
      .en   (en),
      .n    (n_r[p]),
      .nabs (nabs_r[p]),
      .c    (c_r),
      .s    (s_r),
      .d    (d_r[p]),
      .neg  (neg[p])
    );
  end

  // Result register: the box is out when any plane leaves all corners behind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_r[3].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_test_r <= ctl_r[3].is_test;
      inside_r  <= ctl_r[3].is_test && (!ctl_r[3].has_body || !(|neg));
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.inside_res = inside_r;
  assign out_if.is_test    = is_test_r;

  // A load acknowledge never reports a box as inside.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.is_test |-> !out_if.inside_res)
    else $error("load acknowledge carries inside_res");

  // A test of a box without a body always reports inside.
  assert property (@(posedge clk) disable iff (!rst_n)
    en && ctl_r[3].valid && ctl_r[3].is_test && !ctl_r[3].has_body |=> inside_r)
    else $error("box without body reported outside");

  // A stall freezes the stage control.
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_r[0]) && $stable(ctl_r[3]))
    else $error("pipeline moved during stall");

  // When the pipeline moves with no request in its last stage, no result follows.
  assert property (@(posedge clk) disable iff (!rst_n)
    en && !ctl_r[3].valid |=> !out_valid_r)
    else $error("result without request");

endmodule

`default_nettype wire
